// ===== design/assert_macros.svh =====
// Assertion shorthands used by the checker file dabf08_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked on clk, also checked across reset.
`define ASSERT_CLK_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/dabf08_pkg.sv =====
package dabf08_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int KEY_W       = 36;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 2;

  // parse phases
  localparam logic [1:0] PH_SID    = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_FORM   = 2'd2;
  localparam logic [1:0] PH_EXTRA  = 2'd3;

  // record kinds
  localparam logic [1:0] KIND_END   = 2'd0;
  localparam logic [1:0] KIND_TRUNC = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  // bit positions in the result tdata
  localparam int TD_LONG   = 37;
  localparam int TD_RESERR = 57;
  localparam int TD_REPEAT = 58;
  localparam int TD_FULL   = 59;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] service_id;
    logic [3:0]  subid;
    logic        ext_present;
    logic        long_form;
    logic        fic_carried;
    logic [5:0]  channel_id;
    logic [11:0] component_id;
    logic        reserved_error;
    logic        repeat_seen;
    logic        table_full;
    logic        end_of_fig;
  } res_t;

endpackage

// ===== design/dabf08_ram.sv =====
module dabf08_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/dab_fig0_8_component_parser_unit.sv =====
// A result is held in pend and then in the output register, which waits for m_axis_tready;
//   a header byte ending the FIG gives its result once its key search through the key RAM is done.
// Input: one byte per cycle for id and form bytes; a byte with a result stalls input until it
//   is passed on, and a header byte stalls it for its key search (one key compare per cycle).
// Reset (rst, synchronous): parser back to the first id byte, key table empty, programme mode.
module dab_fig0_8_component_parser_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration: data_service_mode
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_data,
  // tdata: byte_value[7:0]; tlast: fig_last
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [dabf08_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                                 s_axis_tlast,
  // tdata: service_id[31:0], component_subid[35:32], ext_present[36], long_form[37],
  //   fic_carried[38], channel_id[44:39], component_id[56:45], reserved_error[57],
  //   repeat_seen[58], table_full[59], zero[63:60]
  // tuser: record_kind[1:0]; tlast: end_of_fig
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [dabf08_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic [dabf08_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  output logic                                 m_axis_tlast
);

  import dabf08_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0]        state;
  logic              data_service_mode;
  logic [1:0]        phase;
  logic [1:0]        byte_cnt;
  logic [31:0]       id_acc;
  logic [2:0]        flags;
  logic [CNT_W-1:0]  seen_count;
  logic [CNT_W-1:0]  idx;
  logic              cmp_valid;

  logic [7:0]        hdr;
  logic [7:0]        form;
  logic [KEY_W-1:0]  key;
  logic              hdr_last;
  res_t              pend;
  res_t              out_res;

  logic              in_acc;
  logic [31:0]       acc_shift;
  logic              id_done;
  res_t              hdr_res;
  res_t              item_res;
  logic              item_has_res;
  res_t              fin_res;

  logic [KEY_W-1:0]  rd_data;
  logic              hit;
  logic              issue;
  logic              miss;
  logic              has_room;
  logic              search_done;
  logic [2:0]        fin_flags;
  logic              ram_re;
  logic              ram_we;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tdata = {4'b0000, out_res.table_full, out_res.repeat_seen,
                         out_res.reserved_error, out_res.component_id, out_res.channel_id,
                         out_res.fic_carried, out_res.long_form, out_res.ext_present,
                         out_res.subid, out_res.service_id};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.end_of_fig;

  // byte-level parse of the incoming beat
  always_comb begin
    acc_shift = {id_acc[23:0], s_axis_tdata};
    id_done   = data_service_mode ? (byte_cnt == 2'd3) : (byte_cnt != 2'd0);

    hdr_res                = '0;
    hdr_res.service_id     = id_acc;
    hdr_res.subid          = hdr[3:0];
    hdr_res.ext_present    = hdr[7];
    hdr_res.reserved_error = flags[0];
    hdr_res.repeat_seen    = flags[1];
    hdr_res.table_full     = flags[2];

    item_res     = '0;
    item_has_res = 1'b0;
    case (phase)
      PH_SID: begin
        if (s_axis_tlast) begin
          item_res.kind = KIND_END;
          item_has_res  = 1'b1;
        end
      end
      PH_FORM: begin
        if (!s_axis_tdata[7] && !hdr[7]) begin
          item_res             = hdr_res;
          item_res.kind        = KIND_FULL;
          item_res.fic_carried = s_axis_tdata[6];
          item_res.channel_id  = s_axis_tdata[5:0];
          item_has_res         = 1'b1;
        end else if (s_axis_tlast) begin
          item_res      = hdr_res;
          item_res.kind = KIND_TRUNC;
          item_has_res  = 1'b1;
        end
      end
      PH_EXTRA: begin
        item_res      = hdr_res;
        item_res.kind = KIND_FULL;
        item_has_res  = 1'b1;
        if (form[7]) begin
          item_res.long_form      = 1'b1;
          item_res.component_id   = {form[3:0], s_axis_tdata};
          item_res.reserved_error = flags[0] | (|form[6:4]);
        end else begin
          item_res.fic_carried    = form[6];
          item_res.channel_id     = form[5:0];
          item_res.reserved_error = flags[0] | (|s_axis_tdata);
        end
      end
      default: ;
    endcase
    item_res.end_of_fig = s_axis_tlast & item_has_res;
  end

  // key table search: one read issued and one compare per cycle
  always_comb begin
    hit         = cmp_valid && (rd_data == key);
    issue       = (idx < seen_count) && !hit;
    miss        = !hit && !issue && !cmp_valid;
    has_room    = (seen_count < CNT_W'(TABLE_DEPTH));
    search_done = hit || miss;
    fin_flags   = {flags[2] | (miss && !has_room), flags[1] | hit, flags[0]};
    ram_re      = (state == ST_SEARCH) && issue;
    ram_we      = (state == ST_SEARCH) && miss && has_room;

    fin_res                = hdr_res;
    fin_res.kind           = KIND_TRUNC;
    fin_res.reserved_error = fin_flags[0];
    fin_res.repeat_seen    = fin_flags[1];
    fin_res.table_full     = fin_flags[2];
    fin_res.end_of_fig     = 1'b1;
  end

  dabf08_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (seen_count[ADDR_W-1:0]),
    .wdata (key),
    .re    (ram_re),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_data)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      data_service_mode <= 1'b0;
      phase             <= PH_SID;
      byte_cnt          <= 2'd0;
      id_acc            <= '0;
      flags             <= '0;
      seen_count        <= '0;
      idx               <= '0;
      cmp_valid         <= 1'b0;
      m_axis_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid) begin
        data_service_mode <= cfg_data;
      end
      if (state == ST_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            case (phase)
              PH_SID: begin
                // a last id byte is handled by the restart below
                if (!s_axis_tlast) begin
                  if (id_done) begin
                    id_acc   <= data_service_mode ? acc_shift : {16'h0000, acc_shift[15:0]};
                    phase    <= PH_HEADER;
                    byte_cnt <= 2'd0;
                  end else begin
                    id_acc   <= acc_shift;
                    byte_cnt <= byte_cnt + 2'd1;
                  end
                end
              end
              PH_HEADER: begin
                flags     <= {2'b00, |s_axis_tdata[6:4]};
                idx       <= '0;
                cmp_valid <= 1'b0;
                state     <= ST_SEARCH;
              end
              PH_FORM: begin
                if (!item_has_res) begin
                  phase <= PH_EXTRA;
                end
              end
              default: ;
            endcase
            if (item_has_res) begin
              state <= ST_EMIT;
            end
            // a header beat that ends the FIG restarts after its search
            if (phase != PH_HEADER && (s_axis_tlast || item_has_res)) begin
              phase    <= PH_SID;
              byte_cnt <= 2'd0;
              id_acc   <= '0;
              flags    <= '0;
            end
          end
        end
        ST_SEARCH: begin
          cmp_valid <= issue;
          if (issue) begin
            idx <= idx + CNT_W'(1);
          end
          if (hit) begin
            seen_count <= '0;
          end else if (ram_we) begin
            seen_count <= seen_count + CNT_W'(1);
          end
          if (search_done) begin
            if (hdr_last) begin
              state    <= ST_EMIT;
              phase    <= PH_SID;
              byte_cnt <= 2'd0;
              id_acc   <= '0;
              flags    <= '0;
            end else begin
              state <= ST_IDLE;
              phase <= PH_FORM;
              flags <= fin_flags;
            end
          end
        end
        ST_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      if (phase == PH_HEADER) begin
        hdr      <= s_axis_tdata;
        key      <= {id_acc, s_axis_tdata[3:0]};
        hdr_last <= s_axis_tlast;
      end
      if (phase == PH_FORM) begin
        form <= s_axis_tdata;
      end
      if (item_has_res) begin
        pend <= item_res;
      end
    end
    if (state == ST_SEARCH && search_done && hdr_last) begin
      pend <= fin_res;
    end
    if (state == ST_EMIT && (!m_axis_tvalid || m_axis_tready)) begin
      out_res <= pend;
    end
  end

endmodule

// ===== design/dabf08_checker.sv =====
`include "assert_macros.svh"

module dabf08_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [dabf08_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [dabf08_pkg::OUT_TUSER_W-1:0] m_axis_tuser,
  input logic                               m_axis_tlast
);

  import dabf08_pkg::*;

  logic end_beat;
  logic rep_and_full;

  assign end_beat     = m_axis_tvalid && (m_axis_tuser == KIND_END);
  assign rep_and_full = m_axis_tdata[TD_REPEAT] && m_axis_tdata[TD_FULL];

  `ASSERT_CLK(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "beat dropped")

  `ASSERT_CLK_ALL(a_rst_clears, rst |=> !m_axis_tvalid, "result valid after reset")

  `ASSERT_CLK(a_end_is_last, end_beat |-> m_axis_tlast, "end marker without end of FIG")

  `ASSERT_CLK(a_end_empty, end_beat |-> m_axis_tdata == '0, "end marker carries fields")

  `ASSERT_CLK(a_repeat_full, m_axis_tvalid |-> !rep_and_full, "repeat and table full together")

endmodule

bind dab_fig0_8_component_parser_unit dabf08_checker u_dabf08_checker (.*);

// ===== verif/component_parser_checker.sv =====
`timescale 1ns / 1ps

module component_parser_checker
  import dabf08_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_data,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   s_axis_tlast,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic [OUT_TUSER_W-1:0] m_axis_tuser,
  input  logic                   m_axis_tlast,
  output int                     outstanding,
  output int                     failures
);

  // parser state
  logic             data_mode;
  logic [1:0]       phase;
  logic [1:0]       id_bytes;
  logic [31:0]      id_acc;
  logic [7:0]       hdr_reg;
  logic [2:0]       flags;    // bit0 reserved error, bit1 repeat, bit2 table full
  logic [7:0]       form_reg;
  logic [KEY_W-1:0] key_store [TABLE_DEPTH];
  int               key_count;

  res_t expected_records[$];
  res_t got;
  res_t want;
  int   mismatch_count;

  // output beat unpacked in res_t field order
  assign got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[35:32], m_axis_tdata[36],
                m_axis_tdata[37], m_axis_tdata[38], m_axis_tdata[44:39], m_axis_tdata[56:45],
                m_axis_tdata[57], m_axis_tdata[58], m_axis_tdata[59], m_axis_tlast};

  function automatic string describe(res_t r);
    return $sformatf({"kind %0d sid %h scids %h ext %b long %b fic %b ch %0d scid %h ",
                      "rsv %b rep %b full %b eof %b"},
                     r.kind, r.service_id, r.subid, r.ext_present, r.long_form, r.fic_carried,
                     r.channel_id, r.component_id, r.reserved_error, r.repeat_seen,
                     r.table_full, r.end_of_fig);
  endfunction

  task automatic lookup_key(input logic [KEY_W-1:0] key);
    bit hit;
    hit = 0;
    for (int k = 0; k < key_count; k++)
      if (key_store[k] == key) hit = 1;
    if (hit) begin
      flags[1] = 1'b1;
      key_count = 0;
    end else if (key_count < TABLE_DEPTH) begin
      key_store[key_count] = key;
      key_count++;
    end else begin
      flags[2] = 1'b1;
    end
  endtask

  task automatic fill_common(inout res_t r);
    r.service_id     = id_acc;
    r.subid          = hdr_reg[3:0];
    r.ext_present    = hdr_reg[7];
    r.reserved_error = flags[0];
    r.repeat_seen    = flags[1];
    r.table_full     = flags[2];
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    res_t r;
    bit   emit;
    int   need;
    r    = '0;
    emit = 0;
    case (phase)
      PH_SID: begin
        // mode is sampled per id byte
        need   = data_mode ? 4 : 2;
        id_acc = {id_acc[23:0], b};
        if (int'(id_bytes) + 1 >= need) begin
          if (!data_mode) id_acc[31:16] = '0;
          phase    = PH_HEADER;
          id_bytes = '0;
        end else begin
          id_bytes = id_bytes + 2'd1;
        end
        if (last) begin
          r.kind = KIND_END;
          emit   = 1;
        end
      end
      PH_HEADER: begin
        hdr_reg = b;
        flags   = {2'b00, |b[6:4]};
        lookup_key({id_acc, b[3:0]});
        if (last) begin
          fill_common(r);
          r.kind = KIND_TRUNC;
          emit   = 1;
        end else begin
          phase = PH_FORM;
        end
      end
      PH_FORM: begin
        form_reg = b;
        if (!b[7] && !hdr_reg[7]) begin
          fill_common(r);
          r.kind        = KIND_FULL;
          r.fic_carried = b[6];
          r.channel_id  = b[5:0];
          emit          = 1;
        end else if (last) begin
          fill_common(r);
          r.kind = KIND_TRUNC;
          emit   = 1;
        end else begin
          phase = PH_EXTRA;
        end
      end
      default: begin
        if (form_reg[7]) begin
          if (|form_reg[6:4]) flags[0] = 1'b1;
          fill_common(r);
          r.long_form    = 1'b1;
          r.component_id = {form_reg[3:0], b};
        end else begin
          if (b != 8'h00) flags[0] = 1'b1;
          fill_common(r);
          r.fic_carried = form_reg[6];
          r.channel_id  = form_reg[5:0];
        end
        r.kind = KIND_FULL;
        emit   = 1;
      end
    endcase
    if (emit) begin
      r.end_of_fig = last;
      expected_records = {expected_records, r};
    end
    if (last || emit) begin
      phase    = PH_SID;
      id_bytes = '0;
      id_acc   = '0;
      flags    = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      data_mode = 1'b0;
      phase     = PH_SID;
      id_bytes  = '0;
      id_acc    = '0;
      hdr_reg   = '0;
      flags     = '0;
      form_reg  = '0;
      key_count = 0;
      mismatch_count = 0;
      expected_records.delete();
    end else begin
      if (cfg_valid && cfg_ready) data_mode = cfg_data;
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_records.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result beat: %s", describe(got));
          mismatch_count++;
        end else begin
          want = expected_records.pop_front();
          if (got !== want) begin
            if (mismatch_count < 10) begin
              $display("result mismatch at %0t", $realtime);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
            mismatch_count++;
          end
        end
      end
    end
    outstanding <= expected_records.size();
    failures    <= mismatch_count;
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import dabf08_pkg::*;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic                   cfg_data;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // byte_value[7:0]
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // service_id .. table_full, see DUT port list
  logic [OUT_TUSER_W-1:0] m_axis_tuser;   // record_kind[1:0]
  logic                   m_axis_tlast;

  int outstanding;
  int failures;

  bit tx_fast;
  bit rx_fast;
  bit hold_rx;
  int items_sent;
  bit cur_mode;

  logic [7:0]  fig_bytes[$];
  logic [31:0] recent_sid[$];
  logic [3:0]  recent_sub[$];

  dab_fig0_8_component_parser_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  component_parser_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .outstanding   (outstanding),
    .failures      (failures)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  initial begin
    #8_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_fig();
    for (int i = 0; i < fig_bytes.size(); i++)
      send_byte(fig_bytes[i], i == fig_bytes.size() - 1);
    fig_bytes.delete();
  endtask

  function automatic void append_byte(input logic [7:0] b);
    fig_bytes = {fig_bytes, b};
  endfunction

  task automatic add_record(input logic [31:0] sid, input logic [7:0] hdr,
                            input logic [7:0] f0, input logic [7:0] f1);
    if (cur_mode) begin
      append_byte(sid[31:24]);
      append_byte(sid[23:16]);
    end
    append_byte(sid[15:8]);
    append_byte(sid[7:0]);
    append_byte(hdr);
    append_byte(f0);
    // long form or extended short form carry a second byte
    if (f0[7] || hdr[7]) append_byte(f1);
  endtask

  // wait for all results, then for a header-byte key search to finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // result side
  initial begin
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        hold_rx = 0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      stall = rx_fast ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    int          budget;
    int          repeat_pct;
    int          cut;
    int          idx;
    logic [31:0] sid;
    logic [3:0]  sub;
    logic [2:0]  rsv;
    logic [7:0]  hdr;
    logic [7:0]  f0;
    logic [7:0]  f1;

    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_data      <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    tx_fast    = 0;
    rx_fast    = 0;
    hold_rx    = 0;
    items_sent = 0;
    cur_mode   = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 8; p++) begin
      settle();
      cur_mode = (p < 4) ? p[0] : 1'($urandom_range(0, 1));
      write_mode(cur_mode);
      tx_fast = (p % 3 == 1);
      rx_fast = (p % 3 == 2);
      if (p == 3) hold_rx = 1;
      // no repeats in the middle phases so the key table fills up
      repeat_pct = (p >= 1 && p <= 4) ? 0 : 25;

      if (p == 0) begin
        // MSC ch 0 with zero ids, then FIC ch 63 with all-ones ids
        add_record(32'h0000_0000, 8'h00, 8'h00, 8'h00);
        add_record(32'h0000_FFFF, 8'h0F, 8'h7F, 8'h00);
        send_fig();
        // same key again, extended short form with nonzero reserved byte
        add_record(32'h0000_FFFF, 8'h8F, 8'h3F, 8'hFF);
        send_fig();
        // long form, reserved bits set in header and form byte
        add_record(32'h0000_1234, 8'hF0, 8'hFF, 8'hFF);
        send_fig();
        // FIG ends on the header
        append_byte(8'h00);
        append_byte(8'hAB);
        append_byte(8'h01);
        send_fig();
        // FIG ends inside the id
        append_byte(8'h5A);
        send_fig();
        // FIG ends on a long form byte that needs its second byte
        add_record(32'h0000_00AB, 8'h02, 8'h80, 8'h00);
        void'(fig_bytes.pop_back());
        send_fig();
      end

      budget = items_sent + 170;
      while (items_sent < budget) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) append_byte(8'($urandom_range(0, 255)));
        end else begin
          repeat ($urandom_range(1, 5)) begin
            if (recent_sid.size() > 0 && $urandom_range(0, 99) < repeat_pct) begin
              idx = $urandom_range(0, recent_sid.size() - 1);
              sid = recent_sid[idx];
              sub = recent_sub[idx];
            end else begin
              sid = $urandom;
              sub = 4'($urandom_range(0, 15));
            end
            if (!cur_mode) sid[31:16] = '0;
            rsv = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
            hdr = {1'($urandom_range(0, 1)), rsv, sub};
            f0  = 8'($urandom_range(0, 255));
            f1  = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 2) == 0) begin
              f0[7]   = 1'b1;
              f0[6:4] = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
            end else begin
              f0[7] = 1'b0;
              if ($urandom_range(0, 7) != 0) f1 = 8'h00;
            end
            add_record(sid, hdr, f0, f1);
            recent_sid = {recent_sid, sid};
            recent_sub = {recent_sub, sub};
            if (recent_sid.size() > 8) begin
              void'(recent_sid.pop_front());
              void'(recent_sub.pop_front());
            end
          end
          if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, 3);
            while (cut > 0 && fig_bytes.size() > 1) begin
              void'(fig_bytes.pop_back());
              cut--;
            end
          end
        end
        send_fig();
      end

      // leave part of an id pending so the next mode change lands mid-id
      if (p < 4 || $urandom_range(0, 2) == 0)
        repeat (cur_mode ? $urandom_range(1, 3) : 1)
          send_byte(8'($urandom_range(0, 255)), 1'b0);
    end

    settle();
    if (failures == 0 && outstanding == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
